FILE: rtl/vac_pkg.sv
package vac_pkg;

	localparam int CompWidth = 16;
	localparam int FracBits = 14;
	localparam int ProdWidth = 2 * CompWidth;
	// squared length: sum of three squares
	localparam int LenWidth = ProdWidth + 1;
	// dot product: signed sum of three products
	localparam int DotWidth = ProdWidth + 2;
	localparam int MagWidth = DotWidth - 1;
	// product of the two squared lengths
	localparam int RadWidth = 2 * LenWidth;
	localparam int RootWidth = LenWidth;
	// remainder of the root recurrence
	localparam int RemWidth = RootWidth + 2;
	// division remainder stays below the root, one extra bit for the doubling
	localparam int DivWidth = RootWidth + 1;
	localparam int OutWidth = FracBits + 2;

	typedef struct packed {
		logic                       valid;
		logic                       degen;
		logic                       neg;
		logic [MagWidth-1:0]        mag;
		logic [RadWidth-1:0]        rad;
		logic [RootWidth-1:0]       root;
		logic [RemWidth-1:0]        rem;
	} sqrt_tok_t;

	typedef struct packed {
		logic                       valid;
		logic                       degen;
		logic                       neg;
		logic                       sat;
		logic [RootWidth-1:0]       den;
		logic [DivWidth-1:0]        rem;
		logic [FracBits-1:0]        quot;
	} div_tok_t;

endpackage

FILE: rtl/vac_sqrt_cell.sv
// one bit of the restoring square root per cell
module vac_sqrt_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  vac_pkg::sqrt_tok_t   tok_in,
	output vac_pkg::sqrt_tok_t   tok_out
);

	logic [vac_pkg::RemWidth-1:0]  rem_sh;
	logic [vac_pkg::RemWidth-1:0]  trial;
	vac_pkg::sqrt_tok_t            nxt;
	logic                          valid_q;
	vac_pkg::sqrt_tok_t            tok_q;

	// bring down the next two radicand bits and try root*4+1
	always_comb begin
		nxt = tok_in;
		rem_sh = {tok_in.rem[vac_pkg::RemWidth-3:0],
			tok_in.rad[vac_pkg::RadWidth-1 -: 2]};
		trial = {tok_in.root, 2'b01};
		nxt.rad = {tok_in.rad[vac_pkg::RadWidth-3:0], 2'b00};
		if (rem_sh >= trial) begin
			nxt.rem = rem_sh - trial;
			nxt.root = {tok_in.root[vac_pkg::RootWidth-2:0], 1'b1};
		end else begin
			nxt.rem = rem_sh;
			nxt.root = {tok_in.root[vac_pkg::RootWidth-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tok_q <= nxt;
		end
	end

	// token to the next cell, valid bit from the reset register
	always_comb begin
		tok_out = tok_q;
		tok_out.valid = valid_q;
	end

endmodule

FILE: rtl/vac_div_cell.sv
// one quotient bit of the restoring division per cell
module vac_div_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  vac_pkg::div_tok_t   tok_in,
	output vac_pkg::div_tok_t   tok_out
);

	logic [vac_pkg::DivWidth-1:0]  rem_sh;
	vac_pkg::div_tok_t             nxt;
	logic                          valid_q;
	vac_pkg::div_tok_t             tok_q;

	always_comb begin
		nxt = tok_in;
		rem_sh = {tok_in.rem[vac_pkg::DivWidth-2:0], 1'b0};
		if (rem_sh >= {1'b0, tok_in.den}) begin
			nxt.rem = rem_sh - {1'b0, tok_in.den};
			nxt.quot = {tok_in.quot[vac_pkg::FracBits-2:0], 1'b1};
		end else begin
			nxt.rem = rem_sh;
			nxt.quot = {tok_in.quot[vac_pkg::FracBits-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tok_q <= nxt;
		end
	end

	// token to the next cell, valid bit from the reset register
	always_comb begin
		tok_out = tok_q;
		tok_out.valid = valid_q;
	end

endmodule

FILE: rtl/vector_angle_cosine.sv
// channel  | signals                                   | direction
// ---------+-------------------------------------------+----------
// in       | valid ready first_x..z second_x..z        | into block
// out      | out_valid out_ready cosine degenerate     | out of block
//
// one transaction per cycle in steady state while the output is not stalled;
// stages in order: products, sums, radicand, square root cells (one root bit
// per cell), division cells (one quotient bit per cell), output register
// reset clears only the valid bits of the pipeline
// a stall at the output freezes the whole pipeline; ready stays high while
// the output register is empty or being taken
module vector_angle_cosine (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                valid,
	output logic                                ready,
	input  logic signed [vac_pkg::CompWidth-1:0] first_x,
	input  logic signed [vac_pkg::CompWidth-1:0] first_y,
	input  logic signed [vac_pkg::CompWidth-1:0] first_z,
	input  logic signed [vac_pkg::CompWidth-1:0] second_x,
	input  logic signed [vac_pkg::CompWidth-1:0] second_y,
	input  logic signed [vac_pkg::CompWidth-1:0] second_z,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [vac_pkg::OutWidth-1:0]  cosine,
	output logic                                degenerate
);

	localparam int SqrtCells = vac_pkg::RootWidth;

	logic en;
	assign en = !out_valid || out_ready;
	assign ready = en;

	// stage 1: the nine products
	logic                                   v_s1;
	logic signed [vac_pkg::ProdWidth-1:0]   pd_s1 [3];
	logic signed [vac_pkg::ProdWidth-1:0]   pa_s1 [3];
	logic signed [vac_pkg::ProdWidth-1:0]   pb_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pd_s1[0] <= first_x * second_x;
			pd_s1[1] <= first_y * second_y;
			pd_s1[2] <= first_z * second_z;
			pa_s1[0] <= first_x * first_x;
			pa_s1[1] <= first_y * first_y;
			pa_s1[2] <= first_z * first_z;
			pb_s1[0] <= second_x * second_x;
			pb_s1[1] <= second_y * second_y;
			pb_s1[2] <= second_z * second_z;
		end
	end

	// stage 2: sums
	logic                                 v_s2;
	logic signed [vac_pkg::DotWidth-1:0]  dot_s2;
	logic [vac_pkg::LenWidth-1:0]         la_s2;
	logic [vac_pkg::LenWidth-1:0]         lb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dot_s2 <= vac_pkg::DotWidth'(pd_s1[0]) + vac_pkg::DotWidth'(pd_s1[1])
				+ vac_pkg::DotWidth'(pd_s1[2]);
			la_s2 <= vac_pkg::LenWidth'(unsigned'(pa_s1[0]))
				+ vac_pkg::LenWidth'(unsigned'(pa_s1[1]))
				+ vac_pkg::LenWidth'(unsigned'(pa_s1[2]));
			lb_s2 <= vac_pkg::LenWidth'(unsigned'(pb_s1[0]))
				+ vac_pkg::LenWidth'(unsigned'(pb_s1[1]))
				+ vac_pkg::LenWidth'(unsigned'(pb_s1[2]));
		end
	end

	// stage 3: radicand product (33x33), sign and magnitude of the dot product
	vac_pkg::sqrt_tok_t sq [SqrtCells+1];
	logic               v_s3;
	vac_pkg::sqrt_tok_t sq_s3;
	vac_pkg::sqrt_tok_t sq_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s3.valid <= v_s2;
			sq_s3.degen <= (la_s2 == '0) || (lb_s2 == '0);
			sq_s3.neg <= dot_s2[vac_pkg::DotWidth-1];
			sq_s3.mag <= dot_s2[vac_pkg::DotWidth-1]
				? vac_pkg::MagWidth'(-dot_s2) : vac_pkg::MagWidth'(dot_s2);
			sq_s3.rad <= vac_pkg::RadWidth'(la_s2) * vac_pkg::RadWidth'(lb_s2);
			sq_s3.root <= '0;
			sq_s3.rem <= '0;
		end
	end

	// head token of the square root row
	always_comb begin
		sq_head = sq_s3;
		sq_head.valid = v_s3;
	end
	assign sq[0] = sq_head;

	// square root cell row
	for (genvar g = 0; g < SqrtCells; g++) begin : g_sqrt
		vac_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.tok_in (sq[g]),
			.tok_out(sq[g+1])
		);
	end

	// division setup: compare against the root
	vac_pkg::div_tok_t dv [vac_pkg::FracBits+1];
	vac_pkg::div_tok_t dv_head;
	vac_pkg::sqrt_tok_t sl;
	logic                  sat;
	assign sl = sq[SqrtCells];
	assign sat = {1'b0, sl.mag} >= (vac_pkg::MagWidth+1)'(sl.root);

	always_comb begin
		dv_head.valid = sl.valid;
		dv_head.degen = sl.degen;
		dv_head.neg = sl.neg;
		dv_head.sat = sat;
		dv_head.den = sl.root;
		dv_head.rem = sat ? '0 : vac_pkg::DivWidth'(sl.mag);
		dv_head.quot = '0;
	end
	assign dv[0] = dv_head;

	// division cell row
	for (genvar g = 0; g < vac_pkg::FracBits; g++) begin : g_div
		vac_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.tok_in (dv[g]),
			.tok_out(dv[g+1])
		);
	end

	// output register: sign, saturation and zero vector override
	vac_pkg::div_tok_t           dl;
	logic [vac_pkg::OutWidth-1:0] mag_out;
	logic [vac_pkg::OutWidth-1:0] one;
	assign dl = dv[vac_pkg::FracBits];
	assign one = vac_pkg::OutWidth'(1) << vac_pkg::FracBits;
	assign mag_out = dl.sat ? one : vac_pkg::OutWidth'(dl.quot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			degenerate <= dl.degen;
			if (dl.degen) begin
				cosine <= signed'(one);
			end else begin
				cosine <= signed'(dl.neg ? -mag_out : mag_out);
			end
		end
	end

	// a result held under stall does not change
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cosine))
		else $error("result changed under stall");
	// degenerate results are exactly 1.0
	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> cosine == signed'(one))
		else $error("degenerate result not 1.0");
	// magnitude never exceeds 1.0
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cosine <= signed'(one)) && (cosine >= -signed'(one)))
		else $error("cosine out of range");

endmodule

FILE: tb/cosine_checker.sv
module cosine_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 valid,
	input  logic                                 ready,
	input  logic signed [vac_pkg::CompWidth-1:0] first_x,
	input  logic signed [vac_pkg::CompWidth-1:0] first_y,
	input  logic signed [vac_pkg::CompWidth-1:0] first_z,
	input  logic signed [vac_pkg::CompWidth-1:0] second_x,
	input  logic signed [vac_pkg::CompWidth-1:0] second_y,
	input  logic signed [vac_pkg::CompWidth-1:0] second_z,
	input  logic                                 out_valid,
	input  logic                                 out_ready,
	input  logic signed [vac_pkg::OutWidth-1:0]  cosine,
	input  logic                                 degenerate,
	output int                                   errors,
	output int                                   pending
);

	typedef struct {
		logic signed [vac_pkg::OutWidth-1:0] cos_val;
		logic                                degen;
	} cosine_result_t;

	localparam longint unsigned UnitCos = 64'd1 << vac_pkg::FracBits;

	cosine_result_t expected_cosines[$];

	// exact dot product, floored root of the squared-length product, truncated quotient
	function automatic cosine_result_t predict_cosine(
		input logic signed [vac_pkg::CompWidth-1:0] ax, ay, az, bx, by, bz);
		cosine_result_t res;
		longint dot;
		longint unsigned len_a, len_b, root, cand, mag, rmd, quot;
		logic [127:0] rad;
		logic neg;
		len_a = longint'(ax) * ax + longint'(ay) * ay + longint'(az) * az;
		len_b = longint'(bx) * bx + longint'(by) * by + longint'(bz) * bz;
		dot = longint'(ax) * bx + longint'(ay) * by + longint'(az) * bz;
		if (len_a == 0 || len_b == 0) begin
			res.cos_val = UnitCos[vac_pkg::OutWidth-1:0];
			res.degen = 1'b1;
			return res;
		end
		rad = 128'(len_a) * 128'(len_b);
		root = 0;
		for (int b = 63; b >= 0; b--) begin
			cand = root | (64'd1 << b);
			if (128'(cand) * 128'(cand) <= rad)
				root = cand;
		end
		neg = dot < 0;
		mag = neg ? unsigned'(-dot) : unsigned'(dot);
		if (mag >= root) begin
			quot = UnitCos;
		end else begin
			rmd = mag;
			quot = 0;
			for (int i = 0; i < vac_pkg::FracBits; i++) begin
				rmd = rmd << 1;
				quot = quot << 1;
				if (rmd >= root) begin
					rmd = rmd - root;
					quot = quot | 1;
				end
			end
		end
		res.cos_val = neg ? vac_pkg::OutWidth'(-quot) : vac_pkg::OutWidth'(quot);
		res.degen = 1'b0;
		return res;
	endfunction

	// predict on each input transaction, compare on each output transaction
	always @(posedge clk or negedge arst_n) begin
		cosine_result_t exp_res;
		if (!arst_n) begin
			errors = 0;
			pending = 0;
			expected_cosines.delete();
		end else begin
			if (valid && ready) begin
				expected_cosines.push_back(predict_cosine(first_x, first_y, first_z,
					second_x, second_y, second_z));
			end
			if (out_valid && out_ready) begin
				if (expected_cosines.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result: cosine %0d degenerate %0b",
							cosine, degenerate);
				end else begin
					exp_res = expected_cosines.pop_front();
					if (cosine !== exp_res.cos_val || degenerate !== exp_res.degen) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: cosine exp %0d got %0d, degenerate exp %0b got %0b",
								exp_res.cos_val, cosine, exp_res.degen, degenerate);
					end
				end
			end
			pending = expected_cosines.size();
		end
	end

endmodule

FILE: tb/tb_vector_angle_cosine.sv
module tb_vector_angle_cosine;

	localparam int RandomPairs = 1080;
	localparam int QuietTail = 150;
	localparam int CycleLimit = 400000;
	localparam int DrainCycles = 80;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic valid = 1'b0;
	logic ready;
	logic signed [vac_pkg::CompWidth-1:0] first_x = '0, first_y = '0, first_z = '0;
	logic signed [vac_pkg::CompWidth-1:0] second_x = '0, second_y = '0, second_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [vac_pkg::OutWidth-1:0] cosine;
	logic degenerate;
	int errors, pending;
	int cycles = 0;
	bit quiet = 1'b0;
	bit hold_req = 1'b0;

	vector_angle_cosine dut (.*);
	cosine_checker checker_i (.*);

	always #10 clk = ~clk;

	// run guard
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	// offer one vector pair and wait for its transaction, then maybe idle
	task automatic send_pair(input logic signed [vac_pkg::CompWidth-1:0] ax, ay, az, bx, by, bz);
		int gap;
		valid <= 1'b1;
		first_x <= ax; first_y <= ay; first_z <= az;
		second_x <= bx; second_y <= by; second_z <= bz;
		do @(posedge clk); while (!ready);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic signed [vac_pkg::CompWidth-1:0] rand_comp(input int span);
		if (span == 0)
			return vac_pkg::CompWidth'($urandom);
		return vac_pkg::CompWidth'(int'($urandom_range(0, 2 * span)) - span);
	endfunction

	// receiver: random stall bursts, one long hold on request
	initial begin
		int n;
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req && !held) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 2) == 0) begin
				n = $urandom_range(1, 10);
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			n = $urandom_range(1, 12);
			out_ready <= 1'b1;
			repeat (n) @(posedge clk);
		end
	end

	// stimulus
	initial begin
		logic signed [vac_pkg::CompWidth-1:0] ax, ay, az, bx, by, bz;
		int k, mode;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero vectors on either side and both
		send_pair(0, 0, 0, 0, 0, 0);
		send_pair(0, 0, 0, 5, -3, 7);
		send_pair(-32768, 1, 2, 0, 0, 0);
		// extremes of the component range
		send_pair(-32768, -32768, -32768, -32768, -32768, -32768);
		send_pair(32767, 32767, 32767, 32767, 32767, 32767);
		send_pair(-32768, -32768, -32768, 32767, 32767, 32767);
		send_pair(32767, -32768, 32767, -32768, 32767, -32768);
		send_pair(-32768, 0, 0, -32768, 0, 0);
		send_pair(32767, 0, 0, 0, 32767, 0);
		// parallel and antiparallel, where the floored root saturates
		send_pair(1, 1, 1, 2, 2, 2);
		send_pair(3, -4, 5, -6, 8, -10);
		send_pair(1, 2, 3, 1, 2, 3);
		send_pair(1, 0, 0, -1, 0, 0);
		// orthogonal pairs
		send_pair(0, 0, 1, 1, 0, 0);
		send_pair(1, 1, 0, 1, -1, 1);
		send_pair(100, 1, 0, 1, -100, 0);
		// nearly parallel, where the floored root still saturates, then assorted angles
		send_pair(1000, 1000, 1000, 1000, 1000, 1001);
		send_pair(-1, -1, -1, 1, 1, 0);
		send_pair(1, 0, 0, 1, 1, 0);
		send_pair(7, 0, 0, -3, 4, 0);

		for (int i = 0; i < RandomPairs; i++) begin
			if (i == 400)
				hold_req = 1'b1;
			if (i == 700) begin
				valid <= 1'b0;
				do @(posedge clk); while (pending != 0);
			end
			if (i == RandomPairs - QuietTail)
				quiet = 1'b1;
			mode = $urandom_range(0, 9);
			case (mode)
				0, 1, 2: begin
					ax = rand_comp(0); ay = rand_comp(0); az = rand_comp(0);
					bx = rand_comp(0); by = rand_comp(0); bz = rand_comp(0);
				end
				3, 4: begin
					ax = rand_comp(8); ay = rand_comp(8); az = rand_comp(8);
					bx = rand_comp(8); by = rand_comp(8); bz = rand_comp(8);
				end
				5, 6: begin
					// scaled copy, possibly flipped
					ax = rand_comp(200); ay = rand_comp(200); az = rand_comp(200);
					k = int'($urandom_range(1, 150)) * ($urandom_range(0, 1) ? 1 : -1);
					bx = vac_pkg::CompWidth'(ax * k);
					by = vac_pkg::CompWidth'(ay * k);
					bz = vac_pkg::CompWidth'(az * k);
				end
				7: begin
					// copy with a small nudge
					ax = rand_comp(1000); ay = rand_comp(1000); az = rand_comp(1000);
					bx = ax + rand_comp(2); by = ay + rand_comp(2); bz = az - rand_comp(2);
				end
				8: begin
					ax = rand_comp(0); ay = rand_comp(0); az = rand_comp(0);
					bx = '0; by = '0; bz = '0;
					if ($urandom_range(0, 1)) begin
						bx = ax; by = ay; bz = az;
						ax = '0; ay = '0; az = '0;
					end
				end
				default: begin
					ax = $urandom_range(0, 1) ? vac_pkg::CompWidth'(-32768)
						: vac_pkg::CompWidth'(32767);
					ay = rand_comp(0); az = rand_comp(3);
					bx = rand_comp(0);
					by = $urandom_range(0, 1) ? vac_pkg::CompWidth'(-32768)
						: vac_pkg::CompWidth'(32767);
					bz = rand_comp(0);
				end
			endcase
			send_pair(ax, ay, az, bx, by, bz);
		end

		// drain and verdict
		valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DrainCycles) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
